[rtl/ptc_pkg.sv]
// Shared types for the pressure/temperature compensation block.
// Holds the state and micro-step enums, calibration and control structs.
// No dependencies.
package ptc_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 64;

   // Register indexes of the configuration port (byte address 8*index)
   localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
   localparam logic [1:0] REG_PRES_LOW  = 2'd1;
   localparam logic [1:0] REG_PRES_MID  = 2'd2;
   localparam logic [1:0] REG_PRES_HIGH = 2'd3;

   localparam logic OP_TEMPERATURE = 1'b0;
   localparam logic OP_PRESSURE    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } ptc_state_type;

   // Micro-steps; temperature runs T0..T4, pressure P0..P11, in enum order
   typedef enum logic [4:0] {
      U_T0, U_T1, U_T2, U_T3, U_T4,
      U_P0, U_P1, U_P2, U_P3, U_P4, U_P5,
      U_P6, U_P7, U_P8, U_P9, U_P10, U_P11
   } ptc_uop_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } ptc_cal_type;

   typedef struct packed {
      logic        load;
      logic        exec;
      ptc_uop_type uop;
   } ptc_cmd_type;

   typedef struct packed {
      logic busy;
      logic v1_zero;
   } ptc_status_type;

endpackage

[rtl/ptc_if.sv]
// Word channel interfaces: request (op, raw sample) and response.
// Depends on nothing.
interface ptc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [23:0] raw_sample;
   modport source (output valid, output op, output raw_sample, input ready);
   modport sink (input valid, input op, input raw_sample, output ready);
endinterface

interface ptc_rsp_if;
   logic               valid;
   logic               ready;
   logic               sample_kind;
   logic signed [15:0] temperature_centi;
   logic [31:0]        pressure_q24_8;
   logic               divide_guard;
   modport source (output valid, output sample_kind, output temperature_centi,
                   output pressure_q24_8, output divide_guard, input ready);
   modport sink (input valid, input sample_kind, input temperature_centi,
                 input pressure_q24_8, input divide_guard, output ready);
endinterface

[rtl/ptc_mul.sv]
// Low 64 bits of a 64x64 product from three 32x32 partial products.
// Depends on nothing.
module ptc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        busy,
   output logic [63:0] product
);
   logic [63:0] a_ff;
   logic [63:0] b_ff;
   logic [63:0] acc_ff;
   logic [1:0]  phase_ff;
   logic        busy_ff;
   logic [63:0] part;

   always_comb begin
      case (phase_ff)
         2'd0:    part = 64'(a_ff[31:0]) * 64'(b_ff[31:0]);
         2'd1:    part = {32'(a_ff[31:0] * b_ff[63:32]), 32'd0};
         default: part = {32'(a_ff[63:32] * b_ff[31:0]), 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         phase_ff <= 2'd0;
      end else if (busy_ff) begin
         phase_ff <= phase_ff + 2'd1;
         if (phase_ff == 2'd2) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (busy_ff) begin
         acc_ff <= (phase_ff == 2'd0) ? part : acc_ff + part;
      end
   end

   assign busy    = busy_ff;
   assign product = acc_ff;
endmodule

[rtl/ptc_div.sv]
// Signed 64-bit divide truncating toward zero, one quotient bit a cycle.
// Depends on nothing.
module ptc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] den_ff;
   logic        neg_ff;
   logic [6:0]  cnt_ff;
   logic [64:0] shifted;
   logic [65:0] trial;

   assign shifted = {rem_ff, quo_ff[63]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else if (start) begin
         cnt_ff <= 7'd64;
      end else if (cnt_ff != 7'd0) begin
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[63] ^ divisor[63];
         quo_ff <= dividend[63] ? 64'd0 - dividend : dividend;
         den_ff <= divisor[63] ? 64'd0 - divisor : divisor;
         rem_ff <= 64'd0;
      end else if (cnt_ff != 7'd0) begin
         // keep the trial difference when it did not go negative
         if (!trial[65]) begin
            rem_ff <= trial[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end

   assign busy     = (cnt_ff != 7'd0);
   assign quotient = neg_ff ? 64'd0 - quo_ff : quo_ff;
endmodule

[rtl/ptc_dp.sv]
// Compensation datapath: working registers, the shared multiplier and the divider.
// Depends on ptc_pkg, ptc_mul, ptc_div.
module ptc_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  ptc_pkg::ptc_cmd_type    cmd,
   output ptc_pkg::ptc_status_type status,
   input  ptc_pkg::ptc_cal_type    cal,
   input  logic                    in_op,
   input  logic [23:0]             in_raw,
   output logic                    out_kind,
   output logic signed [15:0]      out_temp,
   output logic [31:0]             out_pres,
   output logic                    out_guard
);
   import ptc_pkg::*;

   function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] s);
      return 32'($signed(x) >>> s);
   endfunction

   function automatic logic [63:0] sra64(input logic [63:0] x, input logic [5:0] s);
      return 64'($signed(x) >>> s);
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] x);
      return 64'($signed(x));
   endfunction

   logic [19:0]        a_ff;
   logic               kind_ff;
   logic [31:0]        fine_ff;
   logic [63:0]        v1_ff, v2_ff, sq_ff, x_ff, p_ff;
   logic               zero_ff;
   logic signed [15:0] temp_ff;
   logic [31:0]        pres_ff;
   logic               guard_ff;

   logic        mul_start, div_start, mul_busy, div_busy;
   logic [63:0] mul_a, mul_b, prod, quot;
   logic [31:0] p32, m0, d32, fine_in, t5, tc;
   logic [63:0] tf64, v1p0, p_raw, n_pre, p5_val, v1p6, final_val;
   logic signed [15:0] temp_sat;

   assign p32     = prod[31:0];
   assign m0      = 32'(a_ff >> 3) - {15'd0, cal.t1, 1'b0};
   assign d32     = 32'(a_ff >> 4) - {16'd0, cal.t1};
   assign fine_in = v1_ff[31:0] + sra32(p32, 5'd14);
   assign t5      = (fine_ff << 2) + fine_ff + 32'd128;
   assign tc      = sra32(t5, 5'd8);
   assign tf64    = sx32(fine_ff);
   assign v1p0    = tf64 - 64'd128000;
   assign p_raw   = 64'd1048576 - 64'(a_ff);
   assign n_pre   = (p_raw << 31) - v2_ff;
   assign p5_val  = 64'h0000_8000_0000_0000 + x_ff + (prod << 12);
   assign v1p6    = sra64(prod, 6'd33);
   assign final_val = sra64(p_ff + x_ff + sra64(prod, 6'd19), 6'd8)
                      + (64'(cal.p7) << 4);

   always_comb begin
      if ($signed(tc) > 32'sd32767) temp_sat = 16'sh7fff;
      else if ($signed(tc) < -32'sd32768) temp_sat = -16'sh8000;
      else temp_sat = tc[15:0];
   end

   // Operand select and launch of the multiplier and the divider
   always_comb begin
      mul_a     = 64'd0;
      mul_b     = 64'd0;
      mul_start = 1'b0;
      div_start = 1'b0;
      case (cmd.uop)
         U_T0: begin mul_a = sx32(m0); mul_b = 64'(cal.t2); mul_start = cmd.exec; end
         U_T1: begin mul_a = sx32(d32); mul_b = sx32(d32); mul_start = cmd.exec; end
         U_T2: begin
            mul_a = sx32(sra32(p32, 5'd12)); mul_b = 64'(cal.t3); mul_start = cmd.exec;
         end
         U_P0: begin mul_a = v1p0; mul_b = v1p0; mul_start = cmd.exec; end
         U_P1: begin mul_a = prod; mul_b = 64'(cal.p6); mul_start = cmd.exec; end
         U_P2: begin mul_a = v1_ff; mul_b = 64'(cal.p5); mul_start = cmd.exec; end
         U_P3: begin mul_a = sq_ff; mul_b = 64'(cal.p3); mul_start = cmd.exec; end
         U_P4: begin mul_a = v1_ff; mul_b = 64'(cal.p2); mul_start = cmd.exec; end
         U_P5: begin mul_a = p5_val; mul_b = {48'd0, cal.p1}; mul_start = cmd.exec; end
         U_P6: begin
            mul_a = n_pre; mul_b = 64'd3125; mul_start = cmd.exec && (v1p6 != 64'd0);
         end
         U_P7: div_start = cmd.exec;
         U_P8: begin
            mul_a = 64'(cal.p9); mul_b = sra64(quot, 6'd13); mul_start = cmd.exec;
         end
         U_P9: begin mul_a = prod; mul_b = sra64(p_ff, 6'd13); mul_start = cmd.exec; end
         U_P10: begin mul_a = 64'(cal.p8); mul_b = p_ff; mul_start = cmd.exec; end
         default: begin end
      endcase
   end

   ptc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .busy(mul_busy), .product(prod)
   );

   ptc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(prod), .divisor(v1_ff),
      .busy(div_busy), .quotient(quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_ff <= 32'd0;
         zero_ff <= 1'b0;
      end else if (cmd.load) begin
         zero_ff <= 1'b0;
      end else if (cmd.exec) begin
         if (cmd.uop == U_T3) fine_ff <= fine_in;
         if (cmd.uop == U_P6) zero_ff <= (v1p6 == 64'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= in_raw[23:4];
         kind_ff <= in_op;
      end
      if (cmd.exec) begin
         case (cmd.uop)
            U_T1: v1_ff <= sx32(sra32(p32, 5'd11));
            U_T4: begin
               temp_ff  <= temp_sat;
               pres_ff  <= 32'd0;
               guard_ff <= 1'b0;
            end
            U_P0: v1_ff <= v1p0;
            U_P1: sq_ff <= prod;
            U_P2: v2_ff <= prod;
            U_P3: v2_ff <= v2_ff + (prod << 17) + (64'(cal.p4) << 35);
            U_P4: x_ff  <= sra64(prod, 6'd8);
            U_P6: begin
               v1_ff    <= v1p6;
               temp_ff  <= 16'sd0;
               pres_ff  <= 32'd0;
               guard_ff <= (v1p6 == 64'd0);
            end
            U_P8:  p_ff <= quot;
            U_P10: x_ff <= sra64(prod, 6'd25);
            U_P11: begin
               temp_ff  <= 16'sd0;
               pres_ff  <= final_val[31:0];
               guard_ff <= 1'b0;
            end
            default: begin end
         endcase
      end
   end

   assign status.busy    = mul_busy | div_busy;
   assign status.v1_zero = zero_ff;
   assign out_kind  = kind_ff;
   assign out_temp  = temp_ff;
   assign out_pres  = pres_ff;
   assign out_guard = guard_ff;
endmodule

[rtl/ptc_ctrl.sv]
// Sequencer: walks the micro-steps of one word and runs the handshakes.
// Depends on ptc_pkg.
module ptc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ptc_pkg::ptc_status_type status,
   output ptc_pkg::ptc_cmd_type    cmd
);
   import ptc_pkg::*;

   ptc_state_type state_ff, state_in;
   ptc_uop_type   uop_ff, uop_in;
   logic          last_step;

   assign last_step = (uop_ff == U_T4) || (uop_ff == U_P11)
                      || ((uop_ff == U_P6) && status.v1_zero);

   // Next state
   always_comb begin
      state_in = state_ff;
      uop_in   = uop_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = ST_ISSUE;
            uop_in   = (req_op == OP_PRESSURE) ? U_P0 : U_T0;
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: if (!status.busy) begin
            if (last_step) state_in = ST_DONE;
            else begin
               state_in = ST_ISSUE;
               uop_in   = ptc_uop_type'(uop_ff + 5'd1);
            end
         end
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.exec  = (state_ff == ST_ISSUE);
      cmd.uop   = uop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         uop_ff   <= U_T0;
      end else begin
         state_ff <= state_in;
         uop_ff   <= uop_in;
      end
   end

   a_no_issue_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !status.busy) else $error("step issued while a unit is busy");
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("accepted a second word");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready)) else $error("ready while result pending");
endmodule

[rtl/pressure_temperature_compensation.sv]
// Top level of the barometric compensation block.
// Depends on ptc_pkg, ptc_if, ptc_ctrl, ptc_dp.
//
// One word at a time: a request word carries op (0 temperature, 1 pressure)
// and a 24-bit raw reading; one response word comes back per request. A
// temperature word runs three multiplies of the shared unit plus sequencing
// and updates the kept fine temperature. A pressure word runs ten multiplies
// and the radix-2 divider; if the divisor is zero it ends after the seventh
// step with divide_guard set. Calibration lives in four 64-bit APB registers
// at byte addresses 0, 8, 16 and 24; write them only while idle.
module pressure_temperature_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   ptc_req_if.sink                              req,
   ptc_rsp_if.source                            rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ptc_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [ptc_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [ptc_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import ptc_pkg::*;

   logic [47:0]    temp_cal_ff;
   logic [63:0]    pres_low_ff;
   logic [63:0]    pres_mid_ff;
   logic [15:0]    pres_high_ff;
   logic [1:0]     reg_index;
   logic           csr_write;
   ptc_cal_type    cal;
   ptc_cmd_type    cmd;
   ptc_status_type status;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:3];
   assign csr_write = psel && penable && pwrite;

   // Hold calibration; take a write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff  <= 48'd0;
         pres_low_ff  <= 64'd0;
         pres_mid_ff  <= 64'd0;
         pres_high_ff <= 16'd0;
      end else if (csr_write) begin
         case (reg_index)
            REG_TEMP_CAL:  temp_cal_ff  <= pwdata[47:0];
            REG_PRES_LOW:  pres_low_ff  <= pwdata;
            REG_PRES_MID:  pres_mid_ff  <= pwdata;
            REG_PRES_HIGH: pres_high_ff <= pwdata[15:0];
            default: begin end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_TEMP_CAL:  prdata = {16'd0, temp_cal_ff};
         REG_PRES_LOW:  prdata = pres_low_ff;
         REG_PRES_MID:  prdata = pres_mid_ff;
         REG_PRES_HIGH: prdata = {48'd0, pres_high_ff};
         default:       prdata = 64'd0;
      endcase
   end

   // Unpack the coefficients
   assign cal.t1 = temp_cal_ff[15:0];
   assign cal.t2 = temp_cal_ff[31:16];
   assign cal.t3 = temp_cal_ff[47:32];
   assign cal.p1 = pres_low_ff[15:0];
   assign cal.p2 = pres_low_ff[31:16];
   assign cal.p3 = pres_low_ff[47:32];
   assign cal.p4 = pres_low_ff[63:48];
   assign cal.p5 = pres_mid_ff[15:0];
   assign cal.p6 = pres_mid_ff[31:16];
   assign cal.p7 = pres_mid_ff[47:32];
   assign cal.p8 = pres_mid_ff[63:48];
   assign cal.p9 = pres_high_ff;

   ptc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_op(req.op), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd)
   );

   ptc_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .cal(cal),
      .in_op(req.op), .in_raw(req.raw_sample),
      .out_kind(rsp.sample_kind), .out_temp(rsp.temperature_centi),
      .out_pres(rsp.pressure_q24_8), .out_guard(rsp.divide_guard)
   );
endmodule
